// ===== src/teg_pkg.sv =====
// ----------------------------------------------------------------------------
// teg_pkg
// Shared types and constants for the thermal erosion grid pass.
// ----------------------------------------------------------------------------
package teg_pkg;

    localparam int MAX_COLS = 64;
    localparam int MAX_ROWS = 64;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int ADDR_W   = ROW_W + COL_W;
    localparam int DEPTH    = MAX_COLS * MAX_ROWS;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_RUN   = 2'd2;

    localparam logic [2:0] REG_GRID_WIDTH  = 3'd0;
    localparam logic [2:0] REG_GRID_HEIGHT = 3'd1;
    localparam logic [2:0] REG_MOVE_AMOUNT = 3'd2;
    localparam logic [2:0] REG_SLOPE_THR   = 3'd3;
    localparam logic [2:0] REG_PASS_COUNT  = 3'd4;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [5:0]         col;
        logic [5:0]         row;
        logic signed [15:0] height_in;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] height_out;
        logic               run_done;
    } t_out_item;

    typedef enum logic [2:0] {
        SEL_HOST = 3'b001,
        SEL_SCAN = 3'b010,
        SEL_NBR  = 3'b100
    } t_addr_sel;

    // controller -> datapath
    typedef struct packed {
        t_addr_sel   addr_sel;
        logic        host_we;
        logic        host_rd;
        logic        load_here;
        logic        clr_best;
        logic        eval_nbr;
        logic        wr_self;
        logic        wr_target;
        logic        rd_target;
        logic [3:0]  nbr_idx;
        logic [ROW_W-1:0] y;
        logic [COL_W-1:0] x;
    } t_ctl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic nbr_ok;
        logic do_move;
    } t_dp_stat;

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        if (v > 18'sd32767) return 16'sh7fff;
        if (v < -18'sd32768) return 16'sh8000;
        return v[15:0];
    endfunction

endpackage

// ===== src/teg_ram.sv =====
// ----------------------------------------------------------------------------
// teg_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module teg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/teg_datapath.sv =====
// ----------------------------------------------------------------------------
// teg_datapath
// Height store, neighbour compare and saturating move.
// ----------------------------------------------------------------------------
module teg_datapath import teg_pkg::*; (
    input  logic               i_clk,
    input  t_ctl_cmd           i_ctl,
    input  t_in_item           i_item,
    input  logic [6:0]         i_w,
    input  logic [6:0]         i_h,
    input  logic [14:0]        i_move,
    input  logic [21:0]        i_thr,
    output t_dp_stat           o_stat,
    output logic signed [15:0] o_rdata
);
    logic [ADDR_W-1:0]  ram_addr;
    logic [15:0]        ram_wdata;
    logic               ram_we;
    logic [15:0]        ram_q;
    logic signed [15:0] r_here;
    logic signed [16:0] r_best;
    logic [ADDR_W-1:0]  r_target;
    logic               r_found;
    logic [ADDR_W-1:0]  r_nbr_q;
    logic [ADDR_W-1:0]  nbr_addr;
    logic signed [1:0]  dy;
    logic signed [1:0]  dx;
    logic signed [ROW_W+1:0] ny;
    logic signed [COL_W+1:0] nx;
    logic               nbr_ok;
    logic               do_move;
    logic signed [16:0] drop;
    logic [23:0]        drop50;
    logic signed [15:0] dec_v;
    logic signed [15:0] inc_v;

    always_comb begin
        case (i_ctl.nbr_idx)
            4'd0, 4'd1, 4'd2: dy = 2'sb11;
            4'd3, 4'd4:       dy = 2'sb00;
            default:          dy = 2'sb01;
        endcase
        case (i_ctl.nbr_idx)
            4'd0, 4'd3, 4'd5: dx = 2'sb11;
            4'd1, 4'd6:       dx = 2'sb00;
            default:          dx = 2'sb01;
        endcase
        ny = $signed({2'b00, i_ctl.y}) + $signed({{ROW_W{dy[1]}}, dy});
        nx = $signed({2'b00, i_ctl.x}) + $signed({{COL_W{dx[1]}}, dx});
        nbr_ok = (ny >= 0) && (nx >= 0)
                 && (ny < $signed({1'b0, i_h})) && (nx < $signed({1'b0, i_w}));
        nbr_addr = {ny[ROW_W-1:0], nx[COL_W-1:0]};
    end

    assign drop    = $signed({r_here[15], r_here}) - $signed({ram_q[15], ram_q});
    assign drop50  = 24'(r_best[15:0]) * 24'd50;
    assign do_move = r_found && (drop50 > {2'b00, i_thr});
    assign o_stat.nbr_ok  = nbr_ok;
    assign o_stat.do_move = do_move;
    assign dec_v = sat16($signed({{2{r_here[15]}}, r_here}) - $signed({3'b000, i_move}));
    assign inc_v = sat16($signed({{2{ram_q[15]}}, ram_q}) + $signed({3'b000, i_move}));

    always_comb begin
        ram_we    = 1'b0;
        ram_wdata = i_item.height_in;
        case (i_ctl.addr_sel)
            SEL_HOST: ram_addr = {i_item.row, i_item.col};
            SEL_NBR:  ram_addr = nbr_addr;
            default:  ram_addr = {i_ctl.y, i_ctl.x};
        endcase
        if (i_ctl.host_we) begin
            ram_we = 1'b1;
        end else if (i_ctl.wr_self) begin
            ram_we = 1'b1;
            ram_wdata = dec_v;
        end else if (i_ctl.wr_target) begin
            ram_we = 1'b1;
            ram_addr = r_target;
            ram_wdata = inc_v;
        end else if (i_ctl.rd_target) begin
            ram_addr = r_target;
        end
    end

    teg_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_q)
    );

    always_ff @(posedge i_clk) begin
        r_nbr_q <= nbr_addr;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_here) begin
            r_here <= ram_q;
        end
        if (i_ctl.clr_best) begin
            r_best  <= '0;
            r_found <= 1'b0;
        end else if (i_ctl.eval_nbr && drop > r_best) begin
            r_best   <= drop;
            r_found  <= 1'b1;
            r_target <= r_nbr_q;
        end
    end

    assign o_rdata = ram_q;
endmodule

// ===== src/teg_ctrl.sv =====
// ----------------------------------------------------------------------------
// teg_ctrl
// Sequencer for host access and erosion passes.
// ----------------------------------------------------------------------------
module teg_ctrl import teg_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_in_item   i_item,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    output t_out_item  o_out,
    input  logic [6:0] i_w,
    input  logic [6:0] i_h,
    input  logic [7:0] i_passes,
    input  t_dp_stat   i_stat,
    input  logic signed [15:0] i_rdata,
    output t_ctl_cmd   o_ctl
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_RDWT  = 8'b00000010,
        S_HERE  = 8'b00000100,
        S_NBR   = 8'b00001000,
        S_DEC   = 8'b00010000,
        S_TRD   = 8'b00100000,
        S_INC   = 8'b01000000,
        S_NEXT  = 8'b10000000
    } t_state;

    t_state r_state, n_state;
    logic [ROW_W-1:0] r_y, n_y;
    logic [COL_W-1:0] r_x, n_x;
    logic [3:0] r_k, n_k;
    logic [7:0] r_p, n_p;
    logic r_ov, n_ov;
    t_out_item r_out, n_out;
    logic r_rd_out, n_rd_out;
    logic r_nbr_ok_q;
    logic [6:0] w_c, h_c;
    logic acc;
    logic last_x, last_y;

    assign w_c = (i_w > 7'(MAX_COLS)) ? 7'(MAX_COLS) : i_w;
    assign h_c = (i_h > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : i_h;
    assign o_ready = (r_state == S_IDLE) && !r_rd_out && (!r_ov || i_out_ready);
    assign acc = i_valid && o_ready;
    assign last_x = ({1'b0, r_x} + 7'd1) >= w_c;
    assign last_y = ({1'b0, r_y} + 7'd1) >= h_c;
    assign o_out_valid = r_ov;
    assign o_out = r_out;

    always_comb begin
        n_state = r_state; n_y = r_y; n_x = r_x; n_k = r_k; n_p = r_p;
        n_ov = r_ov; n_out = r_out; n_rd_out = 1'b0;
        o_ctl = '0;
        o_ctl.addr_sel = SEL_SCAN;
        o_ctl.nbr_idx = r_k;
        o_ctl.y = r_y;
        o_ctl.x = r_x;
        if (r_ov && i_out_ready) n_ov = 1'b0;
        if (r_rd_out) begin
            n_ov = 1'b1;
            n_out.height_out = i_rdata;
            n_out.run_done = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                o_ctl.addr_sel = SEL_HOST;
                if (acc) begin
                    case (i_item.cmd)
                        CMD_WRITE: o_ctl.host_we = 1'b1;
                        CMD_READ:  n_rd_out = 1'b1;
                        CMD_RUN: begin
                            n_y = '0; n_x = '0; n_p = i_passes;
                            n_state = S_NEXT;
                        end
                        default: ;
                    endcase
                end
            end
            S_NEXT: begin
                if (n_p == 8'd0 || w_c == 7'd0 || h_c == 7'd0) begin
                    if (!r_ov) begin
                        n_ov = 1'b1;
                        n_out.height_out = '0;
                        n_out.run_done = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_RDWT;
                end
            end
            S_RDWT: begin
                n_state = S_HERE;
            end
            S_HERE: begin
                o_ctl.load_here = 1'b1;
                o_ctl.clr_best = 1'b1;
                o_ctl.addr_sel = SEL_NBR;
                o_ctl.nbr_idx = 4'd0;
                n_k = 4'd1;
                n_state = S_NBR;
            end
            S_NBR: begin
                // read neighbour r_k while judging neighbour r_k-1
                o_ctl.addr_sel = SEL_NBR;
                o_ctl.nbr_idx = r_k;
                o_ctl.eval_nbr = r_nbr_ok_q;
                n_k = r_k + 4'd1;
                if (r_k == 4'd8) n_state = S_DEC;
            end
            S_DEC: begin
                if (i_stat.do_move) begin
                    o_ctl.wr_self = 1'b1;
                    n_state = S_TRD;
                end else begin
                    n_state = S_INC;
                end
            end
            S_TRD: begin
                o_ctl.rd_target = 1'b1;
                n_state = S_INC;
                n_k = 4'd15;
            end
            S_INC: begin
                if (r_k == 4'd15) o_ctl.wr_target = 1'b1;
                n_k = 4'd0;
                if (last_x) begin
                    n_x = '0;
                    if (last_y) begin
                        n_y = '0;
                        n_p = r_p - 8'd1;
                        n_state = S_NEXT;
                    end else begin
                        n_y = r_y + 1'b1;
                        n_state = S_RDWT;
                    end
                end else begin
                    n_x = r_x + 1'b1;
                    n_state = S_RDWT;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_nbr_ok_q <= i_stat.nbr_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_ov <= 1'b0; r_rd_out <= 1'b0;
            r_y <= '0; r_x <= '0; r_k <= '0; r_p <= '0;
        end else begin
            r_state <= n_state; r_ov <= n_ov; r_rd_out <= n_rd_out;
            r_y <= n_y; r_x <= n_x; r_k <= n_k; r_p <= n_p;
        end
        r_out <= n_out;
    end
endmodule

// ===== src/thermal_erosion_grid_pass.sv =====
// ----------------------------------------------------------------------------
// thermal_erosion_grid_pass
// Heightfield grid with host access and in-place thermal erosion passes.
// ----------------------------------------------------------------------------
// channel   handshake          payload
// in        i_valid/o_ready    i_item (cmd, col, row, height_in)
// out       o_valid/i_ready    o_item (height_out, run_done)
// cfg       APB write/read     grid_width .. pass_count at 4*i
// A write lands in the store on acceptance; a read passes the RAM read and
// result registers. Each cell steps through S_RDWT, S_HERE, S_NBR, S_DEC,
// S_TRD where height moves (RAM single port), S_INC; S_NEXT between passes.
// Reset idles control and loads configuration defaults; the store is undefined until written.
// Input is held off while a run or read is in flight or a result waits untaken.
// ----------------------------------------------------------------------------
module thermal_erosion_grid_pass import teg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in_item    i_item,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_item   o_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [6:0]  r_w, r_h;
    logic [14:0] r_move;
    logic [21:0] r_thr;
    logic [7:0]  r_passes;
    t_ctl_cmd    ctl;
    t_dp_stat    stat;
    logic signed [15:0] rdata;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= 7'd64; r_h <= 7'd64; r_move <= 15'd16; r_thr <= '0; r_passes <= 8'd1;
        end else if (psel && penable && pwrite) begin
            case (paddr[4:2])
                REG_GRID_WIDTH:  r_w <= pwdata[6:0];
                REG_GRID_HEIGHT: r_h <= pwdata[6:0];
                REG_MOVE_AMOUNT: r_move <= pwdata[14:0];
                REG_SLOPE_THR:   r_thr <= pwdata[21:0];
                REG_PASS_COUNT:  r_passes <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_GRID_WIDTH:  prdata = {25'd0, r_w};
            REG_GRID_HEIGHT: prdata = {25'd0, r_h};
            REG_MOVE_AMOUNT: prdata = {17'd0, r_move};
            REG_SLOPE_THR:   prdata = {10'd0, r_thr};
            REG_PASS_COUNT:  prdata = {24'd0, r_passes};
            default:         prdata = '0;
        endcase
    end

    teg_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_item(i_item),
        .i_out_ready(i_ready), .o_out_valid(o_valid), .o_out(o_item),
        .i_w(r_w), .i_h(r_h), .i_passes(r_passes),
        .i_stat(stat), .i_rdata(rdata), .o_ctl(ctl)
    );

    teg_datapath u_dp (
        .i_clk(i_clk), .i_ctl(ctl), .i_item(i_item),
        .i_w(r_w > 7'(MAX_COLS) ? 7'(MAX_COLS) : r_w),
        .i_h(r_h > 7'(MAX_ROWS) ? 7'(MAX_ROWS) : r_h),
        .i_move(r_move), .i_thr(r_thr),
        .o_stat(stat), .o_rdata(rdata)
    );
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the thermal erosion grid pass. A directed table
// loads a small grid with extreme heights and runs one pass. Random phases
// then reprogram the grid size, move amount, threshold and pass count, fill
// the grid in use, and mix writes, reads of loaded cells, runs and unused
// commands. The erosion model or the table checks each result in order.
// ----------------------------------------------------------------------------
module testbench;
    import teg_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int         LIMIT      = 4000000;
    localparam int         NPHASE     = 30;

    typedef struct packed {
        t_in_item  item;
        logic      typed;
        t_out_item want;
    } t_row;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_ready = 1'b0;
    t_in_item    i_item  = '0;
    logic        o_ready;
    logic        o_valid;
    t_out_item   o_item;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [4:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    thermal_erosion_grid_pass DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_item(i_item),
        .o_valid(o_valid), .i_ready(i_ready), .o_item(o_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // grid model and settings
    logic signed [15:0] heights [DEPTH];
    int unsigned cfg_w = 64, cfg_h = 64, cfg_move = 16, cfg_thr = 0, cfg_pass = 1;
    t_out_item   result_q [$];
    logic        cur_typed = 1'b0;
    t_out_item   cur_want  = '0;

    bit  is_written [DEPTH];
    int  written_addr [$];
    bit  send_idle = 1'b1;
    bit  recv_idle = 1'b1;
    bit  hold_req  = 1'b0;
    int  cycles = 0, errors = 0, n_items = 0, n_reads = 0, n_runs = 0;

    function automatic logic signed [15:0] clip16(int v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic void erode_once(int w, int h);
        int here, best, target, ny, nx, drop, self;
        for (int y = 0; y < h; y++) begin
            for (int x = 0; x < w; x++) begin
                self   = y * MAX_COLS + x;
                here   = int'(heights[self]);
                best   = 0;
                target = -1;
                for (int dy = -1; dy <= 1; dy++) begin
                    for (int dx = -1; dx <= 1; dx++) begin
                        ny = y + dy;
                        nx = x + dx;
                        if ((dy != 0 || dx != 0) && ny >= 0 && nx >= 0 && ny < h && nx < w) begin
                            drop = here - int'(heights[ny * MAX_COLS + nx]);
                            if (drop > best) begin
                                best   = drop;
                                target = ny * MAX_COLS + nx;
                            end
                        end
                    end
                end
                if (target >= 0 && longint'(best) * 50 > longint'(cfg_thr)) begin
                    heights[self]   = clip16(int'(heights[self]) - int'(cfg_move));
                    heights[target] = clip16(int'(heights[target]) + int'(cfg_move));
                end
            end
        end
    endfunction

    function automatic void apply_item(t_in_item it, logic typed, t_out_item want);
        t_out_item r;
        int w, h;
        r = '0;
        case (it.cmd)
            CMD_WRITE: heights[it.row * MAX_COLS + it.col] = it.height_in;
            CMD_READ: begin
                r.height_out = heights[it.row * MAX_COLS + it.col];
                result_q.push_back(typed ? want : r);
            end
            CMD_RUN: begin
                w = cfg_w < MAX_COLS ? cfg_w : MAX_COLS;
                h = cfg_h < MAX_ROWS ? cfg_h : MAX_ROWS;
                for (int p = 0; p < cfg_pass; p++) erode_once(w, h);
                r.run_done = 1'b1;
                result_q.push_back(typed ? want : r);
            end
            default: ;
        endcase
    endfunction

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles, result_q.size());
            $display("testbench: FAIL");
            $finish;
        end
    end

    // predict on input transfer, check on output transfer
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) apply_item(i_item, cur_typed, cur_want);
        if (i_rst_n && o_valid && i_ready) begin
            if (result_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", o_item);
            end else begin
                if (o_item.height_out !== result_q[0].height_out ||
                    o_item.run_done !== result_q[0].run_done) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp height %0d done %0b, got height %0d done %0b",
                                 result_q[0].height_out, result_q[0].run_done,
                                 o_item.height_out, o_item.run_done);
                end
                void'(result_q.pop_front());
            end
        end
    end

    // receiver: random stalls and one long hold-off
    initial begin
        int n;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (300) @(negedge i_clk);
                hold_req = 1'b0;
                i_ready <= 1'b1;
            end else if (recv_idle && $urandom_range(0, 5) == 0) begin
                i_ready <= 1'b0;
                n = $urandom_range(1, 19);
                repeat (n) @(negedge i_clk);
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    task automatic send(t_in_item it, logic typed = 1'b0, t_out_item want = '0);
        int n;
        @(negedge i_clk);
        if (send_idle && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            n = $urandom_range(1, 19);
            repeat (n) @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_item    <= it;
        cur_typed <= typed;
        cur_want  <= want;
        if (it.cmd == CMD_WRITE && !is_written[it.row * MAX_COLS + it.col]) begin
            is_written[it.row * MAX_COLS + it.col] = 1'b1;
            written_addr.push_back(it.row * MAX_COLS + it.col);
        end
        if (it.cmd == CMD_READ) n_reads++;
        if (it.cmd == CMD_RUN) n_runs++;
        n_items++;
        forever begin
            @(posedge i_clk);
            if (o_ready) break;
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [2:0] idx, int unsigned val);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            REG_GRID_WIDTH:  cfg_w    = val & 32'h7f;
            REG_GRID_HEIGHT: cfg_h    = val & 32'h7f;
            REG_MOVE_AMOUNT: cfg_move = val & 32'h7fff;
            REG_SLOPE_THR:   cfg_thr  = val & 32'h3fffff;
            REG_PASS_COUNT:  cfg_pass = val & 32'hff;
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_grid(int w, int h, int mv, int thr, int np);
        cfg_write(REG_GRID_WIDTH, w);
        cfg_write(REG_GRID_HEIGHT, h);
        cfg_write(REG_MOVE_AMOUNT, mv);
        cfg_write(REG_SLOPE_THR, thr);
        cfg_write(REG_PASS_COUNT, np);
    endtask

    function automatic t_in_item mk(logic [1:0] c, int col, int row, int hv);
        t_in_item it;
        it.cmd       = c;
        it.col       = 6'(col);
        it.row       = 6'(row);
        it.height_in = 16'(hv);
        return it;
    endfunction

    function automatic int rand_height();
        case ($urandom_range(0, 9))
            0: return -32768;
            1: return 32767;
            default: return int'($signed(16'($urandom)));
        endcase
    endfunction

    t_row directed [] = '{
        '{mk(CMD_WRITE, 0, 0, 32767),  1'b0, '0},
        '{mk(CMD_WRITE, 1, 0, 32760),  1'b0, '0},
        '{mk(CMD_WRITE, 2, 0, 0),      1'b0, '0},
        '{mk(CMD_WRITE, 0, 1, -32760), 1'b0, '0},
        '{mk(CMD_WRITE, 1, 1, -32768), 1'b0, '0},
        '{mk(CMD_WRITE, 2, 1, 5),      1'b0, '0},
        '{mk(CMD_WRITE, 0, 2, 100),    1'b0, '0},
        '{mk(CMD_WRITE, 1, 2, -1),     1'b0, '0},
        '{mk(CMD_WRITE, 2, 2, 7),      1'b0, '0},
        '{mk(CMD_READ, 0, 0, 0),       1'b1, '{16'sh7fff, 1'b0}},
        '{mk(CMD_READ, 1, 1, 0),       1'b1, '{16'sh8000, 1'b0}},
        '{mk(CMD_UNUSED, 63, 63, -1),  1'b0, '0},
        '{mk(CMD_RUN, 0, 0, 0),        1'b1, '{16'sh0000, 1'b1}},
        '{mk(CMD_READ, 0, 0, 0),       1'b0, '0},
        '{mk(CMD_READ, 1, 0, 0),       1'b0, '0},
        '{mk(CMD_READ, 2, 0, 0),       1'b0, '0},
        '{mk(CMD_READ, 0, 1, 0),       1'b0, '0},
        '{mk(CMD_READ, 1, 1, 0),       1'b0, '0},
        '{mk(CMD_READ, 2, 1, 0),       1'b0, '0},
        '{mk(CMD_READ, 0, 2, 0),       1'b0, '0},
        '{mk(CMD_READ, 1, 2, 0),       1'b0, '0},
        '{mk(CMD_READ, 2, 2, 0),       1'b0, '0},
        '{mk(CMD_WRITE, 63, 63, 21845),1'b0, '0},
        '{mk(CMD_READ, 63, 63, 0),     1'b1, '{16'sh5555, 1'b0}},
        '{mk(CMD_RUN, 0, 0, 0),        1'b1, '{16'sh0000, 1'b1}}
    };

    initial begin
        int w, h, mv, thr, np, cw, ch, r, a;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        set_grid(3, 3, 16, 0, 1);
        foreach (directed[k]) send(directed[k].item, directed[k].typed, directed[k].want);
        drain();

        for (int ph = 0; ph < NPHASE; ph++) begin
            send_idle = (ph < NPHASE - 5);
            recv_idle = (ph < NPHASE - 5) && (ph % 4 != 3);
            np = $urandom_range(1, 3);
            case ($urandom_range(0, 7))
                0: begin w = 0; h = $urandom_range(1, 4); end
                1: begin w = 127; h = 1; end
                2: begin w = 1; h = $urandom_range(0, 1) ? 64 : 127; end
                3: begin w = 64; h = 1; end
                4: begin w = $urandom_range(1, 4); h = 0; end
                default: begin w = $urandom_range(1, 6); h = $urandom_range(1, 6); end
            endcase
            case ($urandom_range(0, 3))
                0: mv = 0;
                1: mv = 32767;
                2: mv = $urandom_range(1, 64);
                default: mv = $urandom_range(0, 32767);
            endcase
            case ($urandom_range(0, 3))
                0: thr = 0;
                1: thr = 4194303;
                2: thr = $urandom_range(0, 3000);
                default: thr = $urandom_range(0, 4194303);
            endcase
            if (ph % 9 == 4) np = 0;
            if (ph % 11 == 6) begin w = 3; h = 3; np = 255; end
            set_grid(w, h, mv, thr, np);
            cw = w < MAX_COLS ? w : MAX_COLS;
            ch = h < MAX_ROWS ? h : MAX_ROWS;
            for (int y = 0; y < ch; y++)
                for (int x = 0; x < cw; x++)
                    send(mk(CMD_WRITE, x, y, rand_height()));
            if (ph == 5) hold_req = 1'b1;
            for (int k = 0; k < 40; k++) begin
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    if (cw > 0 && ch > 0 && $urandom_range(0, 3) != 0)
                        send(mk(CMD_WRITE, $urandom_range(0, cw - 1),
                                $urandom_range(0, ch - 1), rand_height()));
                    else
                        send(mk(CMD_WRITE, $urandom_range(0, 63), $urandom_range(0, 63),
                                rand_height()));
                end else if (r < 82 || ph == 5) begin
                    a = written_addr[$urandom_range(0, written_addr.size() - 1)];
                    send(mk(CMD_READ, a % MAX_COLS, a / MAX_COLS, $urandom));
                end else if (r < 93) begin
                    send(mk(CMD_RUN, $urandom_range(0, 63), $urandom_range(0, 63), $urandom));
                end else begin
                    send(mk(CMD_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63), $urandom));
                end
            end
            drain();
        end

        $display("covered %0d items over %0d phases: %0d reads, %0d runs checked in order",
                 n_items, NPHASE + 1, n_reads, n_runs);
        $display("grid sizes from empty to clamped, move and threshold extremes, 0..255 passes");
        if (errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("%0d mismatches", errors);
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/teg_pkg.sv
src/teg_ram.sv
src/teg_datapath.sv
src/teg_ctrl.sv
src/thermal_erosion_grid_pass.sv
tb/testbench.sv
